FILE: hw/rtl/mpthc_pkg.sv
// ----------------------------------------------------------------------------
// Port table package
// Shared types and codes for the port table with half-close: operation codes,
// outcome codes, status bytes, entry mark bits and the controller interface.
// ----------------------------------------------------------------------------
package mpthc_pkg;

  // Operation codes carried with each input item.
  localparam logic [2:0] FN_OPEN         = 3'd0;
  localparam logic [2:0] FN_REMOTE       = 3'd1;
  localparam logic [2:0] FN_LOCAL_EOF    = 3'd2;
  localparam logic [2:0] FN_LOCAL_CLOSE  = 3'd3;
  localparam logic [2:0] FN_DATA         = 3'd4;

  // Outcome codes returned with each result item.
  localparam logic [2:0] OC_OK           = 3'd0;
  localparam logic [2:0] OC_NO_FREE      = 3'd1;
  localparam logic [2:0] OC_CLOSED       = 3'd2;
  localparam logic [2:0] OC_UNKNOWN      = 3'd3;
  localparam logic [2:0] OC_DOUBLE_EOF   = 3'd4;
  localparam logic [2:0] OC_DOUBLE_CLOSE = 3'd5;

  // Status bytes seen on the link and codes sent back.
  localparam logic [7:0] STAT_EOF        = 8'h03;
  localparam logic [7:0] STAT_CLOSE      = 8'h04;
  localparam logic [2:0] SENT_NONE       = 3'd0;
  localparam logic [2:0] SENT_EOF        = 3'd3;
  localparam logic [2:0] SENT_CLOSE      = 3'd4;

  // One table entry: in use, input open, output open.
  typedef logic [2:0] entry_t;
  localparam int unsigned MARK_USE_BIT = 2;
  localparam int unsigned MARK_IN_BIT  = 1;
  localparam int unsigned MARK_OUT_BIT = 0;
  localparam entry_t ENTRY_FREE = 3'b011;
  localparam entry_t ENTRY_BUSY = 3'b111;
  localparam entry_t HALF_IN    = 3'b010;
  localparam entry_t HALF_OUT   = 3'b001;
  localparam entry_t HALF_NONE  = 3'b000;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SEARCH,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic search_start;
    logic lookup;
    logic search_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic in_is_open;
    logic found;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/mpthc_ctrl.sv
// ----------------------------------------------------------------------------
// Port table controller
// Sequences the clearing pass, the target lookup, the free-port search and
// the commit of each item into the output register.
// ----------------------------------------------------------------------------
module mpthc_ctrl
  import mpthc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.in_is_open ? ST_SEARCH : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_EXEC;
      end
      ST_SEARCH: begin
        if (sts.found || sts.exhausted) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_tready        = 1'b1;
        cmd.load_item    = in_tvalid;
        cmd.search_start = in_tvalid && sts.in_is_open;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_SEARCH: begin
        cmd.search_step = !sts.found && !sts.exhausted;
      end
      ST_EXEC: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mpthc_dp.sv
// ----------------------------------------------------------------------------
// Port table datapath
// Holds the port table memory, the item registers, the next-fit search
// pointer and the output register, and works out each item's result.
// ----------------------------------------------------------------------------
module mpthc_dp
  import mpthc_pkg::*;
#(
  parameter int NUM_PORTS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_func,
  input  logic [8:0]  in_port,
  input  logic [7:0]  in_status_code,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [8:0]  out_result_port,
  output logic [2:0]  out_outcome,
  output logic        out_eof_event,
  output logic        out_freed,
  output logic        out_send_status,
  output logic [2:0]  out_sent_code,
  output logic        out_deliver
);

  localparam int AW = $clog2(NUM_PORTS);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PORTS - 1);
  localparam logic [CW-1:0] PROBES    = CW'(NUM_PORTS);

  // Port table memory and its registered read data.
  entry_t        mem [NUM_PORTS];
  entry_t        rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Item registers.
  logic [2:0]    func_r;
  logic [8:0]    port_r;
  logic [7:0]    code_r;

  // Clearing pass and search state.
  logic [AW-1:0] clr_ptr_r;
  logic [AW-1:0] last_alloc_r;
  logic [AW-1:0] scan_ptr_r;
  logic [CW-1:0] probe_cnt_r;
  logic          pend_r;
  logic [AW-1:0] chk_addr_r;
  logic          issue;

  // Output register.
  logic          out_valid_r;
  logic [8:0]    res_port_r;
  logic [2:0]    res_outcome_r;
  logic          res_eof_r;
  logic          res_freed_r;
  logic          res_send_r;
  logic [2:0]    res_code_r;
  logic          res_deliver_r;

  // Result of the current item.
  logic          in_range;
  logic          live;
  logic [AW-1:0] item_addr;
  entry_t        half;
  entry_t        cleared;
  entry_t        new_entry;
  logic          wr_need;
  logic [8:0]    c_port;
  logic [2:0]    c_outcome;
  logic          c_eof;
  logic          c_freed;
  logic          c_send;
  logic [2:0]    c_code;
  logic          c_deliver;
  logic          out_free;

  // Wrap-around increment over the port range.
  function automatic logic [AW-1:0] next_port(input logic [AW-1:0] p);
    next_port = (p == LAST_ADDR) ? '0 : p + 1'b1;
  endfunction

  assign item_addr = AW'(port_r);
  assign in_range  = 32'(port_r) < 32'(NUM_PORTS);
  assign live      = in_range && rd_data_r[MARK_USE_BIT];
  assign out_free  = !out_valid_r || out_tready;
  assign issue     = cmd.search_step && (probe_cnt_r != PROBES);

  // Status to the controller.
  always_comb begin
    sts.clear_done = (clr_ptr_r == LAST_ADDR);
    sts.in_is_open = (in_func == FN_OPEN);
    sts.found      = pend_r && !rd_data_r[MARK_USE_BIT];
    sts.exhausted  = !pend_r && (probe_cnt_r == PROBES);
    sts.out_free   = out_free;
  end

  // Memory port selection.
  always_comb begin
    rd_en   = cmd.lookup || issue;
    rd_addr = cmd.lookup ? item_addr : scan_ptr_r;
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_ptr_r;
      wr_data = (clr_ptr_r < AW'(3)) ? ENTRY_BUSY : ENTRY_FREE;
    end else if (func_r == FN_OPEN) begin
      wr_en   = cmd.commit && sts.found;
      wr_addr = chk_addr_r;
      wr_data = ENTRY_BUSY;
    end else begin
      wr_en   = cmd.commit && wr_need;
      wr_addr = item_addr;
      wr_data = new_entry;
    end
  end

  // Port table memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_func;
      port_r <= in_port;
      code_r <= in_status_code;
    end
  end

  // Clearing pointer and last allocated port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r    <= '0;
      last_alloc_r <= AW'(2);
    end else begin
      if (cmd.clear_step && !sts.clear_done) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
      if (cmd.commit && func_r == FN_OPEN && sts.found) begin
        last_alloc_r <= chk_addr_r;
      end
    end
  end

  // Next-fit search: one probe issued per cycle, each checked in the cycle after it is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      probe_cnt_r <= '0;
    end else if (cmd.search_start) begin
      pend_r      <= 1'b0;
      probe_cnt_r <= '0;
    end else if (cmd.search_step) begin
      pend_r <= issue;
      if (issue) begin
        probe_cnt_r <= probe_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      scan_ptr_r <= next_port(last_alloc_r);
    end else if (issue) begin
      scan_ptr_r <= next_port(scan_ptr_r);
      chk_addr_r <= scan_ptr_r;
    end
  end

  // Result of the item and the updated entry.
  always_comb begin
    c_port    = port_r;
    c_outcome = OC_OK;
    c_eof     = 1'b0;
    c_send    = 1'b0;
    c_code    = SENT_NONE;
    c_deliver = 1'b0;
    half      = HALF_NONE;
    wr_need   = 1'b0;
    case (func_r)
      FN_OPEN: begin
        if (sts.found) begin
          c_port = 9'(chk_addr_r);
        end else begin
          c_port    = '0;
          c_outcome = OC_NO_FREE;
        end
      end
      FN_REMOTE: begin
        if (!live) begin
          c_outcome = OC_CLOSED;
        end else if (code_r == STAT_EOF) begin
          half    = HALF_IN;
          wr_need = 1'b1;
          c_eof   = 1'b1;
          if (!rd_data_r[MARK_IN_BIT]) begin
            c_outcome = OC_DOUBLE_EOF;
          end
        end else if (code_r == STAT_CLOSE) begin
          half    = HALF_OUT;
          wr_need = 1'b1;
          if (!rd_data_r[MARK_OUT_BIT]) begin
            c_outcome = OC_DOUBLE_CLOSE;
          end
        end else begin
          c_outcome = OC_UNKNOWN;
        end
      end
      FN_LOCAL_EOF: begin
        if (!live) begin
          c_outcome = OC_CLOSED;
        end else begin
          half    = HALF_OUT;
          wr_need = 1'b1;
          c_send  = 1'b1;
          c_code  = SENT_EOF;
          if (!rd_data_r[MARK_OUT_BIT]) begin
            c_outcome = OC_DOUBLE_EOF;
          end
        end
      end
      FN_LOCAL_CLOSE: begin
        if (!live) begin
          c_outcome = OC_CLOSED;
        end else begin
          half    = HALF_IN;
          wr_need = 1'b1;
          c_send  = 1'b1;
          c_code  = SENT_CLOSE;
          if (!rd_data_r[MARK_IN_BIT]) begin
            c_outcome = OC_DOUBLE_CLOSE;
          end
        end
      end
      FN_DATA: begin
        if (live) begin
          c_deliver = 1'b1;
        end else begin
          c_outcome = OC_CLOSED;
        end
      end
      default: begin
        c_outcome = OC_OK;
      end
    endcase
  end

  // A port with both halves closed is freed and reopened.
  always_comb begin
    cleared = rd_data_r & ~half;
    if (wr_need && !cleared[MARK_IN_BIT] && !cleared[MARK_OUT_BIT]) begin
      new_entry = ENTRY_FREE;
      c_freed   = 1'b1;
    end else begin
      new_entry = cleared;
      c_freed   = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_port_r    <= c_port;
      res_outcome_r <= c_outcome;
      res_eof_r     <= c_eof;
      res_freed_r   <= c_freed;
      res_send_r    <= c_send;
      res_code_r    <= c_code;
      res_deliver_r <= c_deliver;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_result_port = res_port_r;
  assign out_outcome     = res_outcome_r;
  assign out_eof_event   = res_eof_r;
  assign out_freed       = res_freed_r;
  assign out_send_status = res_send_r;
  assign out_sent_code   = res_code_r;
  assign out_deliver     = res_deliver_r;

  // A result is only committed when the output register can take it.
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("item committed while output register is occupied");

  // The search never probes more ports than the table holds.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    probe_cnt_r <= PROBES)
    else $error("search probe count out of range");

  // A successful open moves the next-fit pointer to the allocated port.
  a_alloc_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && func_r == FN_OPEN && sts.found) |=>
      (last_alloc_r == $past(chk_addr_r)))
    else $error("last allocated port not updated");

  // A commit always presents a result in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed item did not reach the output");

endmodule

FILE: hw/rtl/mux_port_table_half_close_unit.sv
// ----------------------------------------------------------------------------
// Port table with half-close
// Next-fit port allocator for a multiplexed link, tracking in-use, input-open
// and output-open marks for every port.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the in_ stream: in_tuser carries the operation code
// and in_tdata the target port and the remote status byte. Each item yields
// exactly one result item on the out_ stream.
// A status, local EOF/CLOSE or data item first reads the target entry from
// the table memory, then works out the result and writes the entry back.
// An open item scans the table memory one port per cycle from the port after
// the last one allocated, until it finds a free port or has probed all
// NUM_PORTS ports; the single table read port sets this rate.
// The next item is accepted in the cycle after a result is committed, so the
// block takes no new item before it is through with the last one.
// After reset the block writes the reset contents into every table entry
// (ports 0 to 2 in use) and accepts no item meanwhile.
// The result sits in an output register: when the receiver stalls, the next
// item is still accepted and worked on, and waits to commit until the
// register is taken.
// ----------------------------------------------------------------------------
module mux_port_table_half_close_unit
  import mpthc_pkg::*;
#(
  parameter int NUM_PORTS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // port [8:0], status_code [16:9], zero fill
  input  logic [2:0]  in_tuser,   // func [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // result_port [8:0], outcome [11:9],
                                  // eof_event [12], freed [13],
                                  // send_status [14], sent_code [17:15],
                                  // deliver [18], zero fill
);

  cmd_t       cmd;
  sts_t       sts;
  logic [8:0] res_port;
  logic [2:0] res_outcome;
  logic       res_eof;
  logic       res_freed;
  logic       res_send;
  logic [2:0] res_code;
  logic       res_deliver;

  // Sequencing.
  mpthc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, search and result logic.
  mpthc_dp #(
    .NUM_PORTS (NUM_PORTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_tuser),
    .in_port         (in_tdata[8:0]),
    .in_status_code  (in_tdata[16:9]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_result_port (res_port),
    .out_outcome     (res_outcome),
    .out_eof_event   (res_eof),
    .out_freed       (res_freed),
    .out_send_status (res_send),
    .out_sent_code   (res_code),
    .out_deliver     (res_deliver)
  );

  // Result packing.
  assign out_tdata = {5'd0, res_deliver, res_code, res_send, res_freed, res_eof,
                      res_outcome, res_port};

endmodule
